// ----- design/hsq_pkg.sv -----
// ----------------------------------------------------------------------------
// hsq_pkg - shared types and constants of the homing sequencer
// Op codes, stage encoding, outcome codes, register indexes and the
// item, result and configuration structures.
// ----------------------------------------------------------------------------
package hsq_pkg;

  localparam int MASK_W = 8;
  localparam int CNT_W  = 16;
  localparam int EFF_W  = 11;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // item kinds
  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_CYCLE  = 2'd1;
  localparam logic [1:0] OP_CANCEL = 2'd2;

  // drive modes
  localparam logic [3:0] MODE_NONE   = 4'd0;
  localparam logic [3:0] MODE_HOMING = 4'd6;
  localparam logic [3:0] MODE_TORQUE = 4'd10;

  // control-word modes
  localparam logic [1:0] CW_ENABLE       = 2'd0;
  localparam logic [1:0] CW_SWITCH_ON    = 2'd1;
  localparam logic [1:0] CW_HOMING_START = 2'd2;

  // outcome codes
  localparam logic [2:0] OC_RUNNING     = 3'd0;
  localparam logic [2:0] OC_SUCCESS     = 3'd1;
  localparam logic [2:0] OC_ENABLE_TO   = 3'd2;
  localparam logic [2:0] OC_CLEAR_TO    = 3'd3;
  localparam logic [2:0] OC_HOMING_ERR  = 3'd4;
  localparam logic [2:0] OC_TRIGGER_TO  = 3'd5;

  // phases
  localparam logic [1:0] PH_PREPARE = 2'd0;
  localparam logic [1:0] PH_PRELOAD = 2'd1;
  localparam logic [1:0] PH_ORIGIN  = 2'd2;

  // stage numbers as reported in failed_stage
  localparam logic [2:0] STG_ENABLE    = 3'd0;
  localparam logic [2:0] STG_CLEAR_DIS = 3'd1;
  localparam logic [2:0] STG_CLEAR_EN  = 3'd2;
  localparam logic [2:0] STG_PRELOAD   = 3'd3;
  localparam logic [2:0] STG_SETTLE    = 3'd4;
  localparam logic [2:0] STG_TRIGGER   = 3'd5;

  // configuration register indexes
  localparam logic [2:0] REG_PRELOAD_EFFORT  = 3'd0;
  localparam logic [2:0] REG_PRELOAD_CYCLES  = 3'd1;
  localparam logic [2:0] REG_SETTLE_CYCLES   = 3'd2;
  localparam logic [2:0] REG_EDGE_CYCLES     = 3'd3;
  localparam logic [2:0] REG_ENABLE_TIMEOUT  = 3'd4;
  localparam logic [2:0] REG_CLEAR_TIMEOUT   = 3'd5;
  localparam logic [2:0] REG_TRIGGER_TIMEOUT = 3'd6;

  localparam logic signed [EFF_W-1:0] RST_PRELOAD_EFFORT = -11'sd800;
  localparam logic [CNT_W-1:0] RST_PRELOAD_CYCLES  = 16'd2000;
  localparam logic [CNT_W-1:0] RST_SETTLE_CYCLES   = 16'd1000;
  localparam logic [CNT_W-1:0] RST_EDGE_CYCLES     = 16'd1000;
  localparam logic [CNT_W-1:0] RST_TIMEOUT         = 16'd2000;

  typedef enum logic [5:0] {
    ST_ENABLE    = 6'b000001,
    ST_CLEAR_DIS = 6'b000010,
    ST_CLEAR_EN  = 6'b000100,
    ST_PRELOAD   = 6'b001000,
    ST_SETTLE    = 6'b010000,
    ST_TRIGGER   = 6'b100000
  } stage_t;

  typedef struct packed {
    logic signed [EFF_W-1:0] preload_effort;
    logic [CNT_W-1:0]        preload_cycles;
    logic [CNT_W-1:0]        settle_cycles;
    logic [CNT_W-1:0]        edge_cycles;
    logic [CNT_W-1:0]        enable_timeout;
    logic [CNT_W-1:0]        clear_timeout;
    logic [CNT_W-1:0]        trigger_timeout;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        op;
    logic [MASK_W-1:0] disabled_mask;
    logic [MASK_W-1:0] op_enabled_bits;
    logic [MASK_W-1:0] homing_attained_bits;
    logic [MASK_W-1:0] homing_error_bits;
  } item_t;

  typedef struct packed {
    logic [3:0]              drive_mode;
    logic signed [EFF_W-1:0] effort_value;
    logic [MASK_W-1:0]       drive_mask;
    logic [1:0]              cw_mode;
    logic                    running;
    logic [2:0]              outcome;
    logic [1:0]              phase;
    logic [MASK_W-1:0]       failed_mask;
    logic [2:0]              failed_stage;
  } result_t;

  function automatic logic [2:0] stage_num(input stage_t s);
    logic [2:0] n;
    unique case (s)
      ST_ENABLE:    n = STG_ENABLE;
      ST_CLEAR_DIS: n = STG_CLEAR_DIS;
      ST_CLEAR_EN:  n = STG_CLEAR_EN;
      ST_PRELOAD:   n = STG_PRELOAD;
      ST_SETTLE:    n = STG_SETTLE;
      ST_TRIGGER:   n = STG_TRIGGER;
      default:      n = STG_ENABLE;
    endcase
    return n;
  endfunction

  function automatic logic [1:0] phase_of(input stage_t s);
    logic [1:0] p;
    unique case (s)
      ST_ENABLE, ST_CLEAR_DIS, ST_CLEAR_EN: p = PH_PREPARE;
      ST_PRELOAD:                           p = PH_PRELOAD;
      ST_SETTLE, ST_TRIGGER:                p = PH_ORIGIN;
      default:                              p = PH_PREPARE;
    endcase
    return p;
  endfunction

endpackage

// ----- design/hsq_in_if.sv -----
// ----------------------------------------------------------------------------
// hsq_in_if - status item channel
// Valid/ready channel carrying one item kind and the per-actuator status masks.
// ----------------------------------------------------------------------------
interface hsq_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] disabled_mask;
  logic [7:0] op_enabled_bits;
  logic [7:0] homing_attained_bits;
  logic [7:0] homing_error_bits;

  modport source (
    output valid, op, disabled_mask, op_enabled_bits, homing_attained_bits,
           homing_error_bits,
    input  ready
  );
  modport sink (
    input  valid, op, disabled_mask, op_enabled_bits, homing_attained_bits,
           homing_error_bits,
    output ready
  );
endinterface

// ----- design/hsq_out_if.sv -----
// ----------------------------------------------------------------------------
// hsq_out_if - command result channel
// Valid/ready channel carrying the drive command and sequence status.
// ----------------------------------------------------------------------------
interface hsq_out_if;
  logic              valid;
  logic              ready;
  logic [3:0]        drive_mode;
  logic signed [10:0] effort_value;
  logic [7:0]        drive_mask;
  logic [1:0]        cw_mode;
  logic              running;
  logic [2:0]        outcome;
  logic [1:0]        phase;
  logic [7:0]        failed_mask;
  logic [2:0]        failed_stage;

  modport source (
    output valid, drive_mode, effort_value, drive_mask, cw_mode,
           running, outcome, phase, failed_mask, failed_stage,
    input  ready
  );
  modport sink (
    input  valid, drive_mode, effort_value, drive_mask, cw_mode,
           running, outcome, phase, failed_mask, failed_stage,
    output ready
  );
endinterface

// ----- design/hsq_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// hsq_cfg_regs - configuration register file
// Seven write-only timing and effort registers with their reset defaults.
// ----------------------------------------------------------------------------
module hsq_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [15:0]   cfg_wdata,
  output hsq_pkg::cfg_t cfg
);
  import hsq_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_PRELOAD_EFFORT:  cfg_nxt.preload_effort  = $signed(cfg_wdata[EFF_W-1:0]);
        REG_PRELOAD_CYCLES:  cfg_nxt.preload_cycles  = cfg_wdata;
        REG_SETTLE_CYCLES:   cfg_nxt.settle_cycles   = cfg_wdata;
        REG_EDGE_CYCLES:     cfg_nxt.edge_cycles     = cfg_wdata;
        REG_ENABLE_TIMEOUT:  cfg_nxt.enable_timeout  = cfg_wdata;
        REG_CLEAR_TIMEOUT:   cfg_nxt.clear_timeout   = cfg_wdata;
        REG_TRIGGER_TIMEOUT: cfg_nxt.trigger_timeout = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.preload_effort  <= RST_PRELOAD_EFFORT;
      cfg_r.preload_cycles  <= RST_PRELOAD_CYCLES;
      cfg_r.settle_cycles   <= RST_SETTLE_CYCLES;
      cfg_r.edge_cycles     <= RST_EDGE_CYCLES;
      cfg_r.enable_timeout  <= RST_TIMEOUT;
      cfg_r.clear_timeout   <= RST_TIMEOUT;
      cfg_r.trigger_timeout <= RST_TIMEOUT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- design/hsq_seq_core.sv -----
// ----------------------------------------------------------------------------
// hsq_seq_core - homing stage sequencer
// Holds the sequence state and works out the command and status for one
// item in a single pass; state advances on step.
// ----------------------------------------------------------------------------
module hsq_seq_core #(
  parameter int ACTUATORS = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  hsq_pkg::item_t   item,
  input  hsq_pkg::cfg_t    cfg,
  output hsq_pkg::result_t res
);
  import hsq_pkg::*;

  localparam int ActN = (ACTUATORS > MASK_W) ? MASK_W : ACTUATORS;
  localparam logic [MASK_W-1:0] ActMask = MASK_W'(((MASK_W+1)'(1) << ActN) - (MASK_W+1)'(1));

  stage_t            stage_r, stage_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              active_r, active_nxt;
  logic [2:0]        outcome_r, outcome_nxt;
  logic [MASK_W-1:0] excluded_r, excluded_nxt;
  logic [MASK_W-1:0] present_r, present_nxt;
  logic [MASK_W-1:0] progress_r, progress_nxt;
  logic [MASK_W-1:0] attained_r, attained_nxt;
  logic [MASK_W-1:0] failed_r, failed_nxt;
  logic [2:0]        fstage_r, fstage_nxt;

  logic [MASK_W-1:0] en, att, herr, targets, present_en, trig_err, att_upd, pending;
  logic [CNT_W-1:0]  cnt_inc;
  logic signed [CNT_W+1:0] settle_edge;
  logic              homing_tail;
  logic [3:0]        mode;
  logic signed [EFF_W-1:0] effort;
  logic [MASK_W-1:0] drive;
  logic [1:0]        cw;

  assign en         = item.op_enabled_bits & ActMask;
  assign att        = item.homing_attained_bits & ActMask;
  assign herr       = item.homing_error_bits & ActMask;
  assign targets    = ~excluded_r & ActMask;
  assign present_en = present_r | (en & targets);
  assign cnt_inc    = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + CNT_W'(1);
  assign trig_err   = present_r & herr;
  assign att_upd    = attained_r | (present_r & att & progress_r & ~herr);
  assign pending    = present_r & ~att_upd;

  // settle switches to homing mode once the counter passes settle - edge
  assign settle_edge = $signed({2'b00, cfg.settle_cycles}) - $signed({2'b00, cfg.edge_cycles});
  assign homing_tail = $signed({2'b00, cnt_inc}) > settle_edge;

  always_comb begin
    stage_nxt    = stage_r;
    cnt_nxt      = cnt_r;
    active_nxt   = active_r;
    outcome_nxt  = outcome_r;
    excluded_nxt = excluded_r;
    present_nxt  = present_r;
    progress_nxt = progress_r;
    attained_nxt = attained_r;
    failed_nxt   = failed_r;
    fstage_nxt   = fstage_r;
    mode         = MODE_NONE;
    effort       = '0;
    drive        = '0;
    cw           = CW_ENABLE;

    priority if (item.op == OP_START) begin
      active_nxt   = 1'b1;
      outcome_nxt  = OC_RUNNING;
      excluded_nxt = item.disabled_mask;
      present_nxt  = '0;
      progress_nxt = '0;
      attained_nxt = '0;
      failed_nxt   = '0;
      stage_nxt    = ST_ENABLE;
      cnt_nxt      = '0;
    end else if (item.op == OP_CANCEL) begin
      active_nxt = 1'b0;
    end else if (item.op == OP_CYCLE && active_r) begin
      cnt_nxt = cnt_inc;
      unique case (stage_r)
        ST_ENABLE: begin
          mode        = MODE_TORQUE;
          drive       = targets;
          present_nxt = present_en;
          if ((present_en & targets) == targets && present_en != '0) begin
            stage_nxt = ST_CLEAR_DIS;
            cnt_nxt   = '0;
          end else if (cnt_inc >= cfg.enable_timeout) begin
            if (present_en != '0) begin
              stage_nxt = ST_CLEAR_DIS;
              cnt_nxt   = '0;
            end else begin
              // nobody answered: every actuator is blamed
              failed_nxt  = ActMask;
              outcome_nxt = OC_ENABLE_TO;
              active_nxt  = 1'b0;
            end
          end
        end
        ST_CLEAR_DIS: begin
          mode  = MODE_HOMING;
          drive = present_r;
          cw    = CW_SWITCH_ON;
          if ((en & present_r) == '0) begin
            stage_nxt = ST_CLEAR_EN;
            cnt_nxt   = '0;
          end else if (cnt_inc >= cfg.clear_timeout) begin
            failed_nxt  = present_r & en;
            outcome_nxt = OC_CLEAR_TO;
            active_nxt  = 1'b0;
          end
        end
        ST_CLEAR_EN: begin
          mode  = MODE_HOMING;
          drive = present_r;
          if ((present_r & ~en) == '0 && (present_r & att) == '0) begin
            stage_nxt = ST_PRELOAD;
            cnt_nxt   = '0;
          end else if (cnt_inc >= cfg.clear_timeout) begin
            failed_nxt  = present_r & (~en | att) & ActMask;
            outcome_nxt = OC_CLEAR_TO;
            active_nxt  = 1'b0;
          end
        end
        ST_PRELOAD: begin
          mode   = MODE_TORQUE;
          drive  = present_r;
          effort = cfg.preload_effort;
          if (cnt_inc >= cfg.preload_cycles) begin
            stage_nxt = ST_SETTLE;
            cnt_nxt   = '0;
          end
        end
        ST_SETTLE: begin
          mode   = homing_tail ? MODE_HOMING : MODE_TORQUE;
          drive  = present_r;
          effort = cfg.preload_effort;
          if (cnt_inc >= cfg.settle_cycles) begin
            stage_nxt = ST_TRIGGER;
            cnt_nxt   = '0;
          end
        end
        ST_TRIGGER: begin
          mode         = MODE_HOMING;
          drive        = present_r;
          effort       = cfg.preload_effort;
          cw           = CW_HOMING_START;
          failed_nxt   = failed_r | trig_err;
          attained_nxt = att_upd;
          progress_nxt = progress_r | (present_r & ~att & ActMask);
          priority if (trig_err != '0) begin
            outcome_nxt = OC_HOMING_ERR;
            active_nxt  = 1'b0;
          end else if (pending != '0) begin
            if (cnt_inc >= cfg.trigger_timeout) begin
              failed_nxt  = failed_r | trig_err | pending;
              outcome_nxt = OC_TRIGGER_TO;
              active_nxt  = 1'b0;
            end
          end else begin
            outcome_nxt = OC_SUCCESS;
            active_nxt  = 1'b0;
          end
        end
        default: ;
      endcase
      if (!active_nxt && outcome_nxt != OC_SUCCESS) begin
        fstage_nxt = stage_num(stage_r);
      end
    end else begin
      // unused op, or a cycle while idle: state holds
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r    <= ST_ENABLE;
      cnt_r      <= '0;
      active_r   <= 1'b0;
      outcome_r  <= OC_RUNNING;
      excluded_r <= '0;
      present_r  <= '0;
      progress_r <= '0;
      attained_r <= '0;
      failed_r   <= '0;
      fstage_r   <= STG_ENABLE;
    end else if (step) begin
      stage_r    <= stage_nxt;
      cnt_r      <= cnt_nxt;
      active_r   <= active_nxt;
      outcome_r  <= outcome_nxt;
      excluded_r <= excluded_nxt;
      present_r  <= present_nxt;
      progress_r <= progress_nxt;
      attained_r <= attained_nxt;
      failed_r   <= failed_nxt;
      fstage_r   <= fstage_nxt;
    end
  end

  always_comb begin
    res.drive_mode   = mode;
    res.effort_value = effort;
    res.drive_mask   = drive;
    res.cw_mode      = cw;
    res.running      = active_nxt;
    res.outcome      = outcome_nxt;
    res.phase        = phase_of(stage_nxt);
    res.failed_mask  = failed_nxt;
    res.failed_stage = fstage_nxt;
  end

endmodule

// ----- design/multi_axis_homing_sequencer_unit.sv -----
// ----------------------------------------------------------------------------
// multi_axis_homing_sequencer_unit - homing sequencer for several drives
// Input register, single-pass stage logic and result register.
//
//   channel   direction  handshake      payload
//   in_chan   sink       valid / ready  op, disabled_mask, status masks
//   out_chan  source     valid / ready  mode, effort, drive mask, status
//   cfg_*     write      cfg_we         cfg_index, cfg_wdata
//
// one item per clock sustained while out_chan.ready stays high; an item is held in
// the input register, then its result in the result register, which offers it out
// the result register is the only stall point: in_chan.ready stays high
// while the input register is empty or can move into the result register
// rst_n is synchronous; it clears the sequence state and both valid flags
// and restores the register defaults
// ----------------------------------------------------------------------------
module multi_axis_homing_sequencer_unit #(
  parameter int ACTUATORS = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  hsq_in_if.sink     in_chan,
  hsq_out_if.source  out_chan,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [15:0] cfg_wdata
);
  import hsq_pkg::*;

  cfg_t    cfg;
  item_t   item_r, item_nxt;
  logic    item_vld_r, item_vld_nxt;
  result_t res, res_r;
  logic    res_vld_r, res_vld_nxt;
  logic    out_free, step, in_xfer;

  assign out_free = !res_vld_r || out_chan.ready;
  assign step     = item_vld_r && out_free;
  assign in_chan.ready = !item_vld_r || out_free;
  assign in_xfer  = in_chan.valid && in_chan.ready;

  always_comb begin
    item_nxt.op                   = in_chan.op;
    item_nxt.disabled_mask        = in_chan.disabled_mask;
    item_nxt.op_enabled_bits      = in_chan.op_enabled_bits;
    item_nxt.homing_attained_bits = in_chan.homing_attained_bits;
    item_nxt.homing_error_bits    = in_chan.homing_error_bits;
  end

  assign item_vld_nxt = in_xfer ? 1'b1 : (step ? 1'b0 : item_vld_r);
  assign res_vld_nxt  = step ? 1'b1 : (out_chan.ready ? 1'b0 : res_vld_r);

  hsq_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  hsq_seq_core #(
    .ACTUATORS (ACTUATORS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (item_r),
    .cfg   (cfg),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      res_vld_r  <= 1'b0;
    end else begin
      item_vld_r <= item_vld_nxt;
      res_vld_r  <= res_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_r <= item_nxt;
    end
    if (step) begin
      res_r <= res;
    end
  end

  assign out_chan.valid        = res_vld_r;
  assign out_chan.drive_mode   = res_r.drive_mode;
  assign out_chan.effort_value = res_r.effort_value;
  assign out_chan.drive_mask   = res_r.drive_mask;
  assign out_chan.cw_mode      = res_r.cw_mode;
  assign out_chan.running      = res_r.running;
  assign out_chan.outcome      = res_r.outcome;
  assign out_chan.phase        = res_r.phase;
  assign out_chan.failed_mask  = res_r.failed_mask;
  assign out_chan.failed_stage = res_r.failed_stage;

endmodule

// ----- design/hsq_checker.sv -----
// ----------------------------------------------------------------------------
// hsq_checker - port-level checks of the homing sequencer
// Watches the result channel and reset; attached to the top level by bind.
// ----------------------------------------------------------------------------
module hsq_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic [3:0]        mode,
  input logic signed [10:0] effort,
  input logic [7:0]        drive,
  input logic [1:0]        cw,
  input logic              running,
  input logic [2:0]        outcome,
  input logic [1:0]        phase
);
  import hsq_pkg::*;

  // no result may be offered straight after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered after reset");

  // a stalled result stays offered
  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // with no mode commanded nothing is driven
  a_idle_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && mode == MODE_NONE |->
      drive == '0 && effort == '0 && cw == CW_ENABLE)
    else $error("command fields set without a mode");

  // a running sequence has no outcome yet
  a_run_outcome: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && running |-> outcome == OC_RUNNING)
    else $error("outcome set while running");

  // push effort only from preload onwards
  a_effort_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && effort != '0 |-> phase != PH_PREPARE)
    else $error("effort during preparation");

endmodule

bind multi_axis_homing_sequencer_unit hsq_checker u_hsq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .mode      (out_chan.drive_mode),
  .effort    (out_chan.effort_value),
  .drive     (out_chan.drive_mask),
  .cw        (out_chan.cw_mode),
  .running   (out_chan.running),
  .outcome   (out_chan.outcome),
  .phase     (out_chan.phase)
);
